/* design/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the frame transmitter RTL, included by orft_core.
// Both macros expect signals named clock and reset in the enclosing scope.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ORFT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define ORFT_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

/* design/orft_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// orft_pkg
// Types and constants shared by the OOK remote frame transmitter.
// ---------------------------------------------------------------------------
package orft_pkg;

   localparam int TICK_W   = 12;
   localparam int REPEAT_W = 8;
   localparam int REMOTE_W = 16;
   localparam int KEY_W    = 7;
   localparam int FRAME_W  = REMOTE_W + KEY_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = TICK_W;

   localparam logic [4:0] FRAME_BITS = 5'(FRAME_W);

   localparam logic [TICK_W-1:0]   PREAMBLE_RESET = 12'd525;
   localparam logic [TICK_W-1:0]   ZERO_RESET     = 12'd120;
   localparam logic [TICK_W-1:0]   ONE_RESET      = 12'd315;
   localparam logic [REPEAT_W-1:0] REPEAT_RESET   = 8'd150;

   typedef enum logic {
      OP_TICK  = 1'b0,
      OP_START = 1'b1
   } opcode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PREAMBLE = 2'd0,
      CSR_ZERO     = 2'd1,
      CSR_ONE      = 2'd2,
      CSR_REPEAT   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [TICK_W-1:0]   preamble_ticks;
      logic [TICK_W-1:0]   zero_ticks;
      logic [TICK_W-1:0]   one_ticks;
      logic [REPEAT_W-1:0] repeat_count;
   } cfg_type;

   typedef struct packed {
      opcode_type          opcode;
      logic [REMOTE_W-1:0] remote_id;
      logic [KEY_W-1:0]    key_id;
   } req_item_type;

   typedef struct packed {
      logic pin_level;
      logic busy_res;
      logic start_ignored;
   } rsp_item_type;

endpackage

/* design/orft_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// orft_if
// Valid/ready channels of the frame transmitter: request and response.
// ---------------------------------------------------------------------------
interface orft_req_if;
   import orft_pkg::*;

   logic                valid;
   logic                ready;
   opcode_type          opcode;
   logic [REMOTE_W-1:0] remote_id;
   logic [KEY_W-1:0]    key_id;

   modport source (output valid, output opcode, output remote_id, output key_id,
                   input ready);
   modport sink   (input valid, input opcode, input remote_id, input key_id,
                   output ready);
endinterface

interface orft_rsp_if;
   logic valid;
   logic ready;
   logic pin_level;
   logic busy_res;
   logic start_ignored;

   modport source (output valid, output pin_level, output busy_res,
                   output start_ignored, input ready);
   modport sink   (input valid, input pin_level, input busy_res,
                   input start_ignored, output ready);
endinterface

/* design/ook_remote_frame_transmitter.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ook_remote_frame_transmitter
// Drives an on-off-keyed remote pin: preamble, 23 frame bits, repeats.
// ---------------------------------------------------------------------------
//  Channel | Dir | Transfer when        | Payload
//  req_ch  | in  | valid && ready       | opcode, remote_id, key_id
//  rsp_ch  | out | valid && ready       | pin_level, busy_res, start_ignored
//  csr_*   | in  | csr_write            | csr_index, csr_wdata
//
//  One item per cycle sustained while the response side accepts; a result passes
//  from its request transfer through the request register, then a sequencer step
//  into the response register, before it is presented.
//  The sequencer state advances only when an item moves into the response register.
//  A stalled response holds the request register; req_ch.ready drops only then.
//  Synchronous reset clears the pipeline and sequencer and reloads register defaults.
// ---------------------------------------------------------------------------
module ook_remote_frame_transmitter (
   input  logic                            clock,
   input  logic                            reset,
   orft_req_if.sink                        req_ch,
   orft_rsp_if.source                      rsp_ch,
   input  logic                            csr_write,
   input  logic [orft_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [orft_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import orft_pkg::*;

   cfg_type      cfg;
   req_item_type req_item;
   rsp_item_type step_result;

   logic         req_valid_ff, req_valid_in;
   req_item_type req_item_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff;

   logic         req_take;
   logic         advance;

   orft_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   orft_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (req_item_ff),
      .cfg    (cfg),
      .result (step_result)
   );

   assign req_item.opcode    = req_ch.opcode;
   assign req_item.remote_id = req_ch.remote_id;
   assign req_item.key_id    = req_ch.key_id;

   // move the held request on when the response slot is free or draining
   assign advance      = req_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !req_valid_ff || advance;
   assign req_take     = req_ch.valid && req_ch.ready;

   assign req_valid_in = req_take || (req_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_take) begin
         req_item_ff <= req_item;
      end
      if (advance) begin
         rsp_item_ff <= step_result;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.pin_level     = rsp_item_ff.pin_level;
   assign rsp_ch.busy_res      = rsp_item_ff.busy_res;
   assign rsp_ch.start_ignored = rsp_item_ff.start_ignored;

endmodule

/* design/orft_csr.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// orft_csr
// Timing and repeat registers, written through a plain write port.
// ---------------------------------------------------------------------------
module orft_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  logic [orft_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [orft_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output orft_pkg::cfg_type                   cfg
);
   import orft_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_PREAMBLE: cfg_in.preamble_ticks = csr_wdata[TICK_W-1:0];
            CSR_ZERO:     cfg_in.zero_ticks     = csr_wdata[TICK_W-1:0];
            CSR_ONE:      cfg_in.one_ticks      = csr_wdata[TICK_W-1:0];
            CSR_REPEAT:   cfg_in.repeat_count   = csr_wdata[REPEAT_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.preamble_ticks <= PREAMBLE_RESET;
         cfg_ff.zero_ticks     <= ZERO_RESET;
         cfg_ff.one_ticks      <= ONE_RESET;
         cfg_ff.repeat_count   <= REPEAT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* design/orft_core.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// orft_core
// Frame sequencer: preamble, bit timing and repeat counting, one item a step.
// ---------------------------------------------------------------------------
module orft_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  orft_pkg::req_item_type item,
   input  orft_pkg::cfg_type      cfg,
   output orft_pkg::rsp_item_type result
);
   import orft_pkg::*;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_PRE   = 2'd1,
      PH_BIT   = 2'd2,
      PH_ZERO2 = 2'd3
   } phase_type;

   phase_type            phase_ff,        phase_in;
   logic                 level_ff,        level_in;
   logic [FRAME_W-1:0]   frame_ff,        frame_in;
   logic [4:0]           bits_left_ff,    bits_left_in;
   logic [REPEAT_W-1:0]  repeats_left_ff, repeats_left_in;
   logic [TICK_W-1:0]    tick_ff,         tick_in;

   logic                 bit_done;
   logic                 ignored;
   logic [TICK_W-1:0]    tick_inc;
   logic [4:0]           bits_dec;
   logic [REPEAT_W-1:0]  repeats_dec;

   assign tick_inc    = tick_ff + 1'b1;
   assign bits_dec    = bits_left_ff - 1'b1;
   assign repeats_dec = repeats_left_ff - 1'b1;

   always_comb begin
      phase_in        = phase_ff;
      level_in        = level_ff;
      frame_in        = frame_ff;
      bits_left_in    = bits_left_ff;
      repeats_left_in = repeats_left_ff;
      tick_in         = tick_ff;
      bit_done        = 1'b0;
      ignored         = 1'b0;

      if (step) begin
         if (item.opcode == OP_START) begin
            if (phase_ff != PH_IDLE) begin
               ignored = 1'b1;
            end else if (cfg.repeat_count != '0) begin
               frame_in        = {item.remote_id, item.key_id};
               repeats_left_in = cfg.repeat_count;
               bits_left_in    = '0;
               level_in        = 1'b0;
               phase_in        = PH_PRE;
               tick_in         = '0;
            end
         end else begin
            case (phase_ff)
               PH_PRE: begin
                  tick_in = tick_inc;
                  if (tick_inc >= cfg.preamble_ticks) begin
                     level_in     = 1'b0;
                     phase_in     = PH_BIT;
                     bits_left_in = FRAME_BITS;
                     tick_in      = '0;
                  end
               end
               PH_BIT: begin
                  tick_in = tick_inc;
                  if (frame_ff[FRAME_W-1]) begin
                     if (tick_inc >= cfg.one_ticks) begin
                        level_in = ~level_ff;
                        bit_done = 1'b1;
                     end
                  end else if (tick_inc >= cfg.zero_ticks) begin
                     phase_in = PH_ZERO2;
                     tick_in  = '0;
                  end
               end
               PH_ZERO2: begin
                  tick_in = tick_inc;
                  if (tick_inc >= cfg.zero_ticks) begin
                     bit_done = 1'b1;
                  end
               end
               default: begin
                  tick_in = tick_ff;
               end
            endcase

            // rotate so the frame is back in place for the next repeat
            if (bit_done) begin
               frame_in     = {frame_ff[FRAME_W-2:0], frame_ff[FRAME_W-1]};
               tick_in      = '0;
               phase_in     = PH_BIT;
               bits_left_in = bits_dec;
               if (bits_dec == '0) begin
                  repeats_left_in = repeats_dec;
                  if (repeats_dec == '0) begin
                     phase_in = PH_IDLE;
                     level_in = 1'b0;
                  end else begin
                     phase_in = PH_PRE;
                  end
               end
            end
         end
      end
   end

   always_comb begin
      case (phase_in)
         PH_PRE:   result.pin_level = 1'b1;
         PH_BIT:   result.pin_level = level_in;
         PH_ZERO2: result.pin_level = ~level_in;
         default:  result.pin_level = 1'b0;
      endcase
      result.busy_res      = (phase_in != PH_IDLE);
      result.start_ignored = ignored;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         level_ff        <= 1'b0;
         frame_ff        <= '0;
         bits_left_ff    <= '0;
         repeats_left_ff <= '0;
         tick_ff         <= '0;
      end else begin
         phase_ff        <= phase_in;
         level_ff        <= level_in;
         frame_ff        <= frame_in;
         bits_left_ff    <= bits_left_in;
         repeats_left_ff <= repeats_left_in;
         tick_ff         <= tick_in;
      end
   end

   `ORFT_NEVER(a_idle_no_repeats, (phase_ff == PH_IDLE) && (repeats_left_ff != '0), "repeats left while idle")
   `ORFT_NEVER(a_bit_has_bits, ((phase_ff == PH_BIT) || (phase_ff == PH_ZERO2)) && (bits_left_ff == '0), "bit phase with no bits left")
   `ORFT_NEVER(a_pre_has_repeats, (phase_ff == PH_PRE) && (repeats_left_ff == '0), "preamble with no repeats left")
   `ORFT_ASSERT(a_ignored_start_holds, step && (item.opcode == OP_START) && (phase_ff != PH_IDLE) |=> $stable(frame_ff) && $stable(phase_ff) && $stable(tick_ff), "start while busy changed state")

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the OOK remote frame transmitter. Tick and start
// items go in over the request channel; each pin/busy/ignored result is
// checked against a cycle-free model of the preamble, bit and repeat sequencer.
// ---------------------------------------------------------------------------
module tb_top;
   import orft_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int MAX_REPORTS    = 10;
   localparam int ROUND_ITEMS    = 40;
   localparam int ROUNDS         = 2;
   localparam int DEFAULT_TICKS  = 650;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_PREAMBLE,
      SEQ_BIT,
      SEQ_ZERO_TAIL
   } seq_phase_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_write;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   orft_req_if req_if ();
   orft_rsp_if rsp_if ();

   ook_remote_frame_transmitter dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Timing registers and sequencer state as the bench tracks them
   cfg_type             timing;
   seq_phase_type       seq_phase;
   logic                seq_level;
   logic [FRAME_W-1:0]  seq_frame;
   logic [4:0]          seq_bits_left;
   logic [REPEAT_W-1:0] seq_repeats_left;
   logic [TICK_W-1:0]   seq_ticks;

   rsp_item_type pin_expect_q[$];

   int send_idle_pct   = 0;
   int recv_stall_pct  = 0;
   int mismatches      = 0;
   int results_checked = 0;
   int frames_started  = 0;
   int starts_ignored  = 0;
   int idle_cycles     = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Sequencer model
   // -------------------------------------------------------------------------
   function automatic bit interval_elapsed(input logic [TICK_W-1:0] len);
      seq_ticks = seq_ticks + 1'b1;
      return seq_ticks >= len;
   endfunction

   function automatic void finish_bit();
      seq_frame     = {seq_frame[FRAME_W-2:0], seq_frame[FRAME_W-1]};
      seq_ticks     = '0;
      seq_phase     = SEQ_BIT;
      seq_bits_left = seq_bits_left - 1'b1;
      if (seq_bits_left == '0) begin
         seq_repeats_left = seq_repeats_left - 1'b1;
         if (seq_repeats_left == '0) begin
            seq_phase = SEQ_IDLE;
            seq_level = 1'b0;
         end else begin
            seq_phase = SEQ_PREAMBLE;
         end
      end
   endfunction

   function automatic rsp_item_type step_transmitter(input req_item_type item);
      rsp_item_type res;
      res = '0;
      if (item.opcode == OP_START) begin
         if (seq_phase != SEQ_IDLE) begin
            res.start_ignored = 1'b1;
            starts_ignored++;
         end else if (timing.repeat_count != '0) begin
            seq_frame        = {item.remote_id, item.key_id};
            seq_repeats_left = timing.repeat_count;
            seq_bits_left    = '0;
            seq_level        = 1'b0;
            seq_ticks        = '0;
            seq_phase        = SEQ_PREAMBLE;
            frames_started++;
         end
      end else begin
         case (seq_phase)
            SEQ_PREAMBLE: begin
               if (interval_elapsed(timing.preamble_ticks)) begin
                  seq_level     = 1'b0;
                  seq_phase     = SEQ_BIT;
                  seq_bits_left = FRAME_BITS;
                  seq_ticks     = '0;
               end
            end
            SEQ_BIT: begin
               if (seq_frame[FRAME_W-1]) begin
                  // a one toggles the line once its time is up
                  if (interval_elapsed(timing.one_ticks)) begin
                     seq_level = ~seq_level;
                     finish_bit();
                  end
               end else if (interval_elapsed(timing.zero_ticks)) begin
                  seq_phase = SEQ_ZERO_TAIL;
                  seq_ticks = '0;
               end
            end
            SEQ_ZERO_TAIL: begin
               if (interval_elapsed(timing.zero_ticks))
                  finish_bit();
            end
            default: ;
         endcase
      end
      case (seq_phase)
         SEQ_PREAMBLE:  res.pin_level = 1'b1;
         SEQ_BIT:       res.pin_level = seq_level;
         SEQ_ZERO_TAIL: res.pin_level = ~seq_level;
         default:       res.pin_level = 1'b0;
      endcase
      res.busy_res = (seq_phase != SEQ_IDLE);
      return res;
   endfunction

   // -------------------------------------------------------------------------
   // Result side: stall, check, watchdog
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         results_checked++;
         if (pin_expect_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: unexpected result pin %b busy %b ignored %b", $time,
                        rsp_if.pin_level, rsp_if.busy_res, rsp_if.start_ignored);
         end else begin
            want = pin_expect_q.pop_front();
            if (rsp_if.pin_level !== want.pin_level || rsp_if.busy_res !== want.busy_res ||
                rsp_if.start_ignored !== want.start_ignored) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("%0t: result %0d expected pin %b busy %b ignored %b, got %b %b %b",
                           $time, results_checked, want.pin_level, want.busy_res,
                           want.start_ignored, rsp_if.pin_level, rsp_if.busy_res,
                           rsp_if.start_ignored);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // -------------------------------------------------------------------------
   // Shared drivers
   // -------------------------------------------------------------------------
   task automatic send_item(input opcode_type op, input logic [REMOTE_W-1:0] rid,
                            input logic [KEY_W-1:0] kid);
      req_item_type item;
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      item = '{opcode: op, remote_id: rid, key_id: kid};
      req_if.valid     <= 1'b1;
      req_if.opcode    <= op;
      req_if.remote_id <= rid;
      req_if.key_id    <= kid;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      // transfer done; valid stays up for a back-to-back item
      pin_expect_q.push_back(step_transmitter(item));
   endtask

   task automatic send_tick();
      send_item(OP_TICK, REMOTE_W'($urandom), KEY_W'($urandom));
   endtask

   task automatic run_to_idle();
      while (seq_phase != SEQ_IDLE) send_tick();
   endtask

   // Start a frame, poke it with a second start while busy, then let it finish
   task automatic run_frame(input logic [REMOTE_W-1:0] rid, input logic [KEY_W-1:0] kid);
      send_item(OP_START, rid, kid);
      send_tick();
      send_item(OP_START, ~rid, ~kid);
      run_to_idle();
   endtask

   task automatic drain_results();
      req_if.valid <= 1'b0;
      while (pin_expect_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Hold write for one cycle, then drop it for one so writes never abut
   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_PREAMBLE: timing.preamble_ticks = data;
         CSR_ZERO:     timing.zero_ticks     = data;
         CSR_ONE:      timing.one_ticks      = data;
         CSR_REPEAT:   timing.repeat_count   = data[REPEAT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic program_timing(input logic [CSR_DATA_W-1:0] pre, zero, one, rep);
      drain_results();
      write_reg(CSR_PREAMBLE, pre);
      write_reg(CSR_ZERO, zero);
      write_reg(CSR_ONE, one);
      write_reg(CSR_REPEAT, rep);
   endtask

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------
   task automatic test_idle_ticks();
      send_item(OP_TICK, '1, '1);
      send_item(OP_TICK, '0, '0);
      send_tick();
   endtask

   // Reset tick lengths carry the frame through the preamble and into the
   // second half of the first zero; shorter lengths then finish it mid-frame
   task automatic test_default_timing();
      drain_results();
      write_reg(CSR_REPEAT, 12'd1);
      send_item(OP_START, 16'h55AA, 7'h2A);
      repeat (DEFAULT_TICKS) send_tick();
      send_item(OP_START, 16'h0F0F, 7'h11);
      program_timing(12'd1, 12'd1, 12'd1, 12'd1);
      run_to_idle();
   endtask

   // Upper data bits must be dropped, leaving a repeat count of zero
   task automatic test_zero_repeat();
      drain_results();
      write_reg(CSR_REPEAT, 12'h100);
      send_item(OP_START, 16'hBEEF, 7'h33);
      send_tick();
      send_item(OP_START, 16'h1234, 7'h4C);
      send_tick();
   endtask

   task automatic test_zero_lengths();
      program_timing(12'd0, 12'd0, 12'd0, 12'hF02);
      run_frame(16'hA5C3, 7'h5A);
   endtask

   // All-ones, all-zeros and sparse frames with lopsided tick lengths
   task automatic test_extreme_timing();
      program_timing(12'd2, 12'd1, 12'd1, 12'd3);
      run_frame(16'hFFFF, 7'h7F);
      program_timing(12'd1, 12'd3, 12'd1, 12'd1);
      run_frame(16'h0000, 7'h00);
      program_timing(12'd1, 12'd1, 12'd5, 12'd2);
      run_frame(16'h8000, 7'h01);
   endtask

   task automatic test_random_traffic(input int send_pct, input int stall_pct);
      send_idle_pct  = send_pct;
      recv_stall_pct = stall_pct;
      repeat (ROUNDS) begin
         program_timing(12'($urandom_range(0, 6)), 12'($urandom_range(0, 3)),
                        12'($urandom_range(0, 4)),
                        {4'($urandom_range(0, 15)), 8'($urandom_range(0, 2))});
         repeat (ROUND_ITEMS) begin
            if ($urandom_range(99) < 4)
               send_item(OP_START, REMOTE_W'($urandom), KEY_W'($urandom));
            else
               send_tick();
         end
         run_to_idle();
      end
   endtask

   initial begin
      req_if.valid     = 1'b0;
      req_if.opcode    = OP_TICK;
      req_if.remote_id = '0;
      req_if.key_id    = '0;
      rsp_if.ready     = 1'b0;
      csr_write        = 1'b0;
      csr_index        = CSR_PREAMBLE;
      csr_wdata        = '0;
      timing           = '{PREAMBLE_RESET, ZERO_RESET, ONE_RESET, REPEAT_RESET};
      seq_phase        = SEQ_IDLE;
      seq_level        = 1'b0;
      seq_frame        = '0;
      seq_bits_left    = '0;
      seq_repeats_left = '0;
      seq_ticks        = '0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_idle_ticks();
      test_default_timing();
      test_zero_repeat();
      test_zero_lengths();
      test_extreme_timing();
      test_random_traffic(0, 0);
      test_random_traffic(63, 0);
      test_random_traffic(0, 63);
      test_random_traffic(14, 14);
      drain_results();

      $display("Checked %0d results: %0d frames started, %0d starts flagged while busy.",
               results_checked, frames_started, starts_ignored);
      $display("Reset timing, mid-frame writes, zero lengths and repeats, four idle/stall mixes covered.");
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+design
design/orft_pkg.sv
design/orft_if.sv
design/orft_csr.sv
design/orft_core.sv
design/ook_remote_frame_transmitter.sv
sim/tb_top.sv
